// File: sv/vgd_pkg.sv
// Shared types, constants and color tables for the vertical gradient dither pixel block.
package vgd_pkg;

   localparam int COORD_BITS  = 12;
   localparam int HEIGHT_BITS = COORD_BITS + 1;
   // y * 1000 needs ten bits beyond the coordinate
   localparam int NUM_BITS    = COORD_BITS + 10;
   localparam int NOISE_BITS  = 3;
   localparam int CHAN_BITS   = 8;
   localparam int NUM_CH      = 3;
   localparam int CH_IDX_BITS = 2;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic REG_FRAME_HEIGHT = 1'b0;
   localparam logic [HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = HEIGHT_BITS'(1080);

   localparam int ROW_SCALE      = 1000;
   localparam int SEG_MID_START  = 600;
   localparam int SEG_HIGH_START = 750;
   localparam int SPAN_LOW       = 600;
   localparam int SPAN_MID       = 150;
   localparam int SPAN_HIGH      = 250;
   localparam int REM_BITS       = 10;

   // segment offset / span through an exact reciprocal
   localparam int F_SHIFT      = NUM_BITS + 10;
   localparam int RECIP_F_BITS = F_SHIFT - 7;
   localparam int PROD_F_BITS  = NUM_BITS + RECIP_F_BITS;
   localparam int QUO_BITS     = NUM_BITS - 7;
   localparam longint unsigned RF_LOW  =
      ((64'd1 << F_SHIFT) + SPAN_LOW - 1) / SPAN_LOW;
   localparam longint unsigned RF_MID  =
      ((64'd1 << F_SHIFT) + SPAN_MID - 1) / SPAN_MID;
   localparam longint unsigned RF_HIGH =
      ((64'd1 << F_SHIFT) + SPAN_HIGH - 1) / SPAN_HIGH;

   // delta * remainder / span, product below 2**16
   localparam int T_BITS       = 16;
   localparam int R_SHIFT      = 26;
   localparam int RECIP_R_BITS = 19;
   localparam int PROD_R_BITS  = T_BITS + RECIP_R_BITS;
   localparam longint unsigned RR_LOW  =
      ((64'd1 << R_SHIFT) + SPAN_LOW - 1) / SPAN_LOW;
   localparam longint unsigned RR_MID  =
      ((64'd1 << R_SHIFT) + SPAN_MID - 1) / SPAN_MID;
   localparam longint unsigned RR_HIGH =
      ((64'd1 << R_SHIFT) + SPAN_HIGH - 1) / SPAN_HIGH;

   localparam int SHADE_STAGES = 6;
   localparam int LATENCY      = NUM_BITS + SHADE_STAGES + 1;

   localparam logic [CH_IDX_BITS-1:0] CH_RED   = 2'd0;
   localparam logic [CH_IDX_BITS-1:0] CH_GREEN = 2'd1;
   localparam logic [CH_IDX_BITS-1:0] CH_BLUE  = 2'd2;

   typedef enum logic [1:0] {
      SEG_LOW  = 2'd0,
      SEG_MID  = 2'd1,
      SEG_HIGH = 2'd2
   } vgd_seg_type;

   // payload handed from one divider cell to the next
   typedef struct packed {
      logic [NOISE_BITS-1:0]  noise;
      logic [NUM_BITS-1:0]    num;
      logic [HEIGHT_BITS-1:0] rem;
      logic [NUM_BITS-1:0]    quo;
   } vgd_div_type;

   function automatic logic [REM_BITS-1:0] seg_span(input vgd_seg_type seg);
      logic [REM_BITS-1:0] span;
      case (seg)
         SEG_LOW:  span = REM_BITS'(SPAN_LOW);
         SEG_MID:  span = REM_BITS'(SPAN_MID);
         SEG_HIGH: span = REM_BITS'(SPAN_HIGH);
         default:  span = REM_BITS'(SPAN_HIGH);
      endcase
      return span;
   endfunction

   function automatic logic [RECIP_F_BITS-1:0] seg_recip_f(input vgd_seg_type seg);
      logic [RECIP_F_BITS-1:0] recip;
      case (seg)
         SEG_LOW:  recip = RECIP_F_BITS'(RF_LOW);
         SEG_MID:  recip = RECIP_F_BITS'(RF_MID);
         SEG_HIGH: recip = RECIP_F_BITS'(RF_HIGH);
         default:  recip = RECIP_F_BITS'(RF_HIGH);
      endcase
      return recip;
   endfunction

   function automatic logic [RECIP_R_BITS-1:0] seg_recip_r(input vgd_seg_type seg);
      logic [RECIP_R_BITS-1:0] recip;
      case (seg)
         SEG_LOW:  recip = RECIP_R_BITS'(RR_LOW);
         SEG_MID:  recip = RECIP_R_BITS'(RR_MID);
         SEG_HIGH: recip = RECIP_R_BITS'(RR_HIGH);
         default:  recip = RECIP_R_BITS'(RR_HIGH);
      endcase
      return recip;
   endfunction

   function automatic logic [CHAN_BITS-1:0] ch_base(input vgd_seg_type seg,
                                                    input logic [CH_IDX_BITS-1:0] ch);
      logic [CHAN_BITS-1:0] base;
      case (seg)
         SEG_LOW:  base = (ch == CH_RED) ? 8'd12 : (ch == CH_GREEN) ? 8'd20 : 8'd48;
         SEG_MID:  base = (ch == CH_RED) ? 8'd30 : (ch == CH_GREEN) ? 8'd60 : 8'd110;
         SEG_HIGH: base = (ch == CH_RED) ? 8'd20 : (ch == CH_GREEN) ? 8'd80 : 8'd100;
         default:  base = 8'd0;
      endcase
      return base;
   endfunction

   // magnitude of the segment's color delta
   function automatic logic [5:0] ch_mag(input vgd_seg_type seg,
                                         input logic [CH_IDX_BITS-1:0] ch);
      logic [5:0] mag;
      case (seg)
         SEG_LOW:  mag = (ch == CH_RED) ? 6'd18 : (ch == CH_GREEN) ? 6'd40 : 6'd62;
         SEG_MID:  mag = (ch == CH_RED) ? 6'd10 : (ch == CH_GREEN) ? 6'd20 : 6'd10;
         SEG_HIGH: mag = (ch == CH_RED) ? 6'd4  : (ch == CH_GREEN) ? 6'd40 : 6'd35;
         default:  mag = 6'd0;
      endcase
      return mag;
   endfunction

   function automatic logic ch_neg(input vgd_seg_type seg,
                                   input logic [CH_IDX_BITS-1:0] ch);
      logic neg;
      case (seg)
         SEG_LOW:  neg = 1'b0;
         SEG_MID:  neg = (ch != CH_GREEN);
         SEG_HIGH: neg = 1'b1;
         default:  neg = 1'b0;
      endcase
      return neg;
   endfunction

endpackage

// File: sv/vgd_div_cell.sv
// One restoring divider cell: brings in one dividend bit and yields one quotient bit.
module vgd_div_cell import vgd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [HEIGHT_BITS-1:0] divisor,
   input  logic                   up_valid,
   input  vgd_div_type            up_data,
   output logic                   dn_valid,
   output vgd_div_type            dn_data
);

   logic                   valid_ff;
   vgd_div_type            data_ff;
   vgd_div_type            data_in;
   logic [HEIGHT_BITS:0]   trial;
   logic [HEIGHT_BITS:0]   diff;
   logic                   fits;

   always_comb begin
      trial = {up_data.rem, up_data.num[NUM_BITS-1]};
      diff  = trial - {1'b0, divisor};
      fits  = (trial >= {1'b0, divisor});
      data_in.noise = up_data.noise;
      data_in.num   = {up_data.num[NUM_BITS-2:0], 1'b0};
      data_in.rem   = fits ? diff[HEIGHT_BITS-1:0] : trial[HEIGHT_BITS-1:0];
      data_in.quo   = {up_data.quo[NUM_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// File: sv/vgd_shade.sv
// Gradient pipeline: segment select, interpolation, dither, clamp and ARGB packing.
module vgd_shade import vgd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  frac_valid,
   input  logic [NUM_BITS-1:0]   frac,
   input  logic [NOISE_BITS-1:0] noise,
   output logic                  rsp_strobe,
   output logic [31:0]           rsp_pixel_color
);

   // stage 1: pick segment, offset into it
   logic                  s1_valid_ff;
   vgd_seg_type           s1_seg_ff, s1_seg_in;
   logic [NUM_BITS-1:0]   s1_f_ff, s1_f_in;
   logic [NOISE_BITS-1:0] s1_noise_ff;

   always_comb begin
      if (frac < NUM_BITS'(SEG_MID_START)) begin
         s1_seg_in = SEG_LOW;
         s1_f_in   = frac;
      end else if (frac < NUM_BITS'(SEG_HIGH_START)) begin
         s1_seg_in = SEG_MID;
         s1_f_in   = frac - NUM_BITS'(SEG_MID_START);
      end else begin
         s1_seg_in = SEG_HIGH;
         s1_f_in   = frac - NUM_BITS'(SEG_HIGH_START);
      end
   end

   // stage 2: quotient of offset by span
   logic                  s2_valid_ff;
   vgd_seg_type           s2_seg_ff;
   logic [NUM_BITS-1:0]   s2_f_ff;
   logic [QUO_BITS-1:0]   s2_q_ff, s2_q_in;
   logic [NOISE_BITS-1:0] s2_noise_ff;
   logic [PROD_F_BITS-1:0] prod_f;

   assign prod_f  = PROD_F_BITS'(s1_f_ff) * PROD_F_BITS'(seg_recip_f(s1_seg_ff));
   assign s2_q_in = prod_f[F_SHIFT +: QUO_BITS];

   // stage 3: remainder, keep low quotient bits only
   logic                  s3_valid_ff;
   vgd_seg_type           s3_seg_ff;
   logic [REM_BITS-1:0]   s3_r_ff, s3_r_in;
   logic [7:0]            s3_qlo_ff;
   logic [NOISE_BITS-1:0] s3_noise_ff;
   logic [NUM_BITS-1:0]   qspan;

   assign qspan   = NUM_BITS'(s2_q_ff) * NUM_BITS'(seg_span(s2_seg_ff));
   assign s3_r_in = REM_BITS'(s2_f_ff - qspan);

   // stages 4 to 6, per channel
   logic                  s4_valid_ff, s5_valid_ff, s6_valid_ff;
   vgd_seg_type           s4_seg_ff, s5_seg_ff;
   logic [NOISE_BITS-1:0] s4_noise_ff, s5_noise_ff;
   logic [T_BITS-1:0]     s4_t_ff   [NUM_CH];
   logic [T_BITS-1:0]     s4_t_in   [NUM_CH];
   logic [7:0]            s4_p_ff   [NUM_CH];
   logic [7:0]            s4_p_in   [NUM_CH];
   logic [7:0]            s5_qs_ff  [NUM_CH];
   logic [7:0]            s5_qs_in  [NUM_CH];
   logic [7:0]            s5_p_ff   [NUM_CH];
   logic [7:0]            s6_ch_in  [NUM_CH];
   logic [31:0]           color_ff;

   for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
      logic [PROD_R_BITS-1:0] prod_r;
      logic [7:0]             sum;
      logic [7:0]             wrapped;
      logic [8:0]             dithered;

      assign s4_t_in[c] = T_BITS'(ch_mag(s3_seg_ff, CH_IDX_BITS'(c))) * T_BITS'(s3_r_ff);
      assign s4_p_in[c] = 8'(ch_mag(s3_seg_ff, CH_IDX_BITS'(c))) * s3_qlo_ff;

      assign prod_r      = PROD_R_BITS'(s4_t_ff[c]) * PROD_R_BITS'(seg_recip_r(s4_seg_ff));
      assign s5_qs_in[c] = prod_r[R_SHIFT +: 8];

      always_comb begin
         sum      = s5_p_ff[c] + s5_qs_ff[c];
         wrapped  = ch_neg(s5_seg_ff, CH_IDX_BITS'(c))
                    ? ch_base(s5_seg_ff, CH_IDX_BITS'(c)) - sum
                    : ch_base(s5_seg_ff, CH_IDX_BITS'(c)) + sum;
         // noise is stored offset by four
         dithered = {1'b0, wrapped} + 9'(s5_noise_ff);
         if (dithered < 9'd4) begin
            s6_ch_in[c] = 8'd0;
         end else if (dithered > 9'd259) begin
            s6_ch_in[c] = 8'hFF;
         end else begin
            s6_ch_in[c] = 8'(dithered - 9'd4);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= frac_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_seg_ff   <= s1_seg_in;
      s1_f_ff     <= s1_f_in;
      s1_noise_ff <= noise;
      s2_seg_ff   <= s1_seg_ff;
      s2_f_ff     <= s1_f_ff;
      s2_q_ff     <= s2_q_in;
      s2_noise_ff <= s1_noise_ff;
      s3_seg_ff   <= s2_seg_ff;
      s3_r_ff     <= s3_r_in;
      s3_qlo_ff   <= s2_q_ff[7:0];
      s3_noise_ff <= s2_noise_ff;
      s4_seg_ff   <= s3_seg_ff;
      s4_noise_ff <= s3_noise_ff;
      s4_t_ff     <= s4_t_in;
      s4_p_ff     <= s4_p_in;
      s5_seg_ff   <= s4_seg_ff;
      s5_noise_ff <= s4_noise_ff;
      s5_qs_ff    <= s5_qs_in;
      s5_p_ff     <= s4_p_ff;
      color_ff    <= {8'hFF, s6_ch_in[CH_RED], s6_ch_in[CH_GREEN], s6_ch_in[CH_BLUE]};
   end

   assign rsp_strobe      = s6_valid_ff;
   assign rsp_pixel_color = color_ff;

`ifndef ASSERT_OFF
   a_rem_below_span: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (s3_r_ff < seg_span(s3_seg_ff)))
      else $error("segment remainder not below span");

   a_red_quotient: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |->
         (32'(s5_qs_in[CH_RED]) * 32'(seg_span(s4_seg_ff)) <= 32'(s4_t_ff[CH_RED])) &&
         (32'(s4_t_ff[CH_RED]) < (32'(s5_qs_in[CH_RED]) + 32'd1) * 32'(seg_span(s4_seg_ff))))
      else $error("red reciprocal quotient off");

   a_blue_quotient: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |->
         (32'(s5_qs_in[CH_BLUE]) * 32'(seg_span(s4_seg_ff)) <= 32'(s4_t_ff[CH_BLUE])) &&
         (32'(s4_t_ff[CH_BLUE]) < (32'(s5_qs_in[CH_BLUE]) + 32'd1) * 32'(seg_span(s4_seg_ff))))
      else $error("blue reciprocal quotient off");
`endif

endmodule

// File: sv/vertical_gradient_dither_pixel_top.sv
// Vertical gradient background pixel with ordered dither, top level.
// Path: rsp_strobe is raised once the accepted request has passed through one input stage,
// 22 divider cells for the row scaling and six gradient stages.
// Throughput: one pixel per clock; busy stays low and a new pixel may start every cycle.
// The chain of divider cells, one quotient bit each, sets the latency.
// Reset: synchronous; clears all valid flags and loads frame_height with 1080.
module vertical_gradient_dither_pixel_top import vgd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [COORD_BITS-1:0]    req_pixel_x,
   input  logic [COORD_BITS-1:0]    req_pixel_y,
   output logic                     rsp_strobe,
   output logic [31:0]              rsp_pixel_color,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   logic [HEIGHT_BITS-1:0] frame_height_ff, frame_height_in;
   logic [HEIGHT_BITS-1:0] divisor_ff, divisor_in;
   logic                   csr_write;

   assign pready    = 1'b1;
   assign busy      = 1'b0;
   assign csr_write = psel && penable && pwrite && (paddr[2] == REG_FRAME_HEIGHT);

   always_comb begin
      frame_height_in = pwdata[HEIGHT_BITS-1:0];
      // heights of zero and one divide by one
      divisor_in = (frame_height_in > HEIGHT_BITS'(1))
                   ? frame_height_in - HEIGHT_BITS'(1) : HEIGHT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_height_ff <= FRAME_HEIGHT_RESET;
         divisor_ff      <= FRAME_HEIGHT_RESET - HEIGHT_BITS'(1);
      end else if (csr_write) begin
         frame_height_ff <= frame_height_in;
         divisor_ff      <= divisor_in;
      end
   end

   assign prdata = (paddr[2] == REG_FRAME_HEIGHT) ? CSR_DATA_BITS'(frame_height_ff) : '0;

   // input stage: scaled row and dither phase
   logic                   in_valid_ff;
   vgd_div_type            in_data_ff, in_data_in;

   always_comb begin
      in_data_in.num   = NUM_BITS'(req_pixel_y) * NUM_BITS'(ROW_SCALE);
      in_data_in.noise = NOISE_BITS'(3'd7 * req_pixel_x[NOISE_BITS-1:0])
                       + NOISE_BITS'(3'd5 * req_pixel_y[NOISE_BITS-1:0]);
      in_data_in.rem   = '0;
      in_data_in.quo   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
   end

   logic        chain_valid [NUM_BITS+1];
   vgd_div_type chain_data  [NUM_BITS+1];

   assign chain_valid[0] = in_valid_ff;
   assign chain_data[0]  = in_data_ff;

   for (genvar i = 0; i < NUM_BITS; i++) begin : g_cell
      vgd_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .divisor  (divisor_ff),
         .up_valid (chain_valid[i]),
         .up_data  (chain_data[i]),
         .dn_valid (chain_valid[i+1]),
         .dn_data  (chain_data[i+1])
      );
   end

   vgd_shade u_shade (
      .clock           (clock),
      .reset           (reset),
      .frac_valid      (chain_valid[NUM_BITS]),
      .frac            (chain_data[NUM_BITS].quo),
      .noise           (chain_data[NUM_BITS].noise),
      .rsp_strobe      (rsp_strobe),
      .rsp_pixel_color (rsp_pixel_color)
   );

`ifndef ASSERT_OFF
   a_strobe_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result strobe without an accepted transaction");

   a_transaction_answered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("accepted transaction produced no result");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      divisor_ff != '0)
      else $error("row divisor is zero");
`endif

endmodule

// File: tb/sv/vertical_gradient_dither_pixel_checker.sv
// Checker for the gradient pixel block: tracks frame height, predicts colors, compares results.
`timescale 1ns / 100ps

module vertical_gradient_dither_pixel_checker import vgd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic [COORD_BITS-1:0]    req_pixel_x,
   input  logic [COORD_BITS-1:0]    req_pixel_y,
   input  logic                     rsp_strobe,
   input  logic [31:0]              rsp_pixel_color,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   input  logic [CSR_DATA_BITS-1:0] prdata,
   input  logic                     pready,
   output int unsigned              mismatches,
   output int unsigned              outstanding
);

   localparam logic [CSR_ADDR_BITS-1:0] HEIGHT_ADDR = CSR_ADDR_BITS'(4 * REG_FRAME_HEIGHT);

   typedef struct {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [31:0]           color;
   } pixel_color_type;

   logic [HEIGHT_BITS-1:0] height_copy;
   pixel_color_type        color_q[$];
   pixel_color_type        oldest;
   int unsigned            err_count = 0;

   assign mismatches = err_count;

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      err_count++;
   endtask

   // one segment step: truncating divide, keep the low byte
   function automatic logic [7:0] shade(input longint base, input longint delta,
                                        input longint f, input longint span);
      longint v;
      v = base + (delta * f) / span;
      return v[7:0];
   endfunction

   function automatic logic [7:0] dither_clamp(input logic [7:0] c, input longint noise);
      longint v;
      v = longint'(c) + noise;
      if (v < 0)
         v = 0;
      if (v > 255)
         v = 255;
      return v[7:0];
   endfunction

   function automatic logic [31:0] gradient_color(input logic [COORD_BITS-1:0] x,
                                                  input logic [COORD_BITS-1:0] y,
                                                  input logic [HEIGHT_BITS-1:0] h);
      longint     rows;
      longint     frac;
      longint     noise;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      rows = (h > 1) ? longint'(h) - 1 : 1;
      frac = (longint'(y) * 1000) / rows;
      if (frac < 600) begin
         r = shade(12, 18, frac, 600);
         g = shade(20, 40, frac, 600);
         b = shade(48, 62, frac, 600);
      end else if (frac < 750) begin
         r = shade(30, -10, frac - 600, 150);
         g = shade(60, 20, frac - 600, 150);
         b = shade(110, -10, frac - 600, 150);
      end else begin
         // rows past the frame keep extending the last segment
         r = shade(20, -4, frac - 750, 250);
         g = shade(80, -40, frac - 750, 250);
         b = shade(100, -35, frac - 750, 250);
      end
      noise = ((longint'(x) * 7 + longint'(y) * 13) & 7) - 4;
      return {8'hFF, dither_clamp(r, noise), dither_clamp(g, noise), dither_clamp(b, noise)};
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         height_copy <= FRAME_HEIGHT_RESET;
         color_q.delete();
         outstanding <= 0;
      end else begin
         if (psel && penable && pready && paddr == HEIGHT_ADDR) begin
            if (pwrite)
               height_copy <= pwdata[HEIGHT_BITS-1:0];
            else if (prdata !== CSR_DATA_BITS'(height_copy))
               report_mismatch($sformatf("frame_height read %0h, want %0h",
                                         prdata, height_copy));
         end
         // check the result before queueing this edge's transaction
         if (rsp_strobe) begin
            if (color_q.size() == 0) begin
               report_mismatch($sformatf("unexpected pixel_color %08h", rsp_pixel_color));
            end else begin
               oldest = color_q.pop_front();
               if (rsp_pixel_color !== oldest.color)
                  report_mismatch($sformatf("x=%0d y=%0d pixel_color %08h, want %08h",
                                            oldest.x, oldest.y, rsp_pixel_color,
                                            oldest.color));
            end
         end
         if (start && !busy)
            color_q.push_back('{req_pixel_x, req_pixel_y,
                                gradient_color(req_pixel_x, req_pixel_y, height_copy)});
         outstanding <= color_q.size();
      end
   end

endmodule

// File: tb/sv/vertical_gradient_dither_pixel_top_tb.sv
// Testbench top for the gradient pixel block: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module vertical_gradient_dither_pixel_top_tb;
   import vgd_pkg::*;

   localparam logic [CSR_ADDR_BITS-1:0] HEIGHT_ADDR = CSR_ADDR_BITS'(4 * REG_FRAME_HEIGHT);
   localparam int PHASE_PIXELS   = 113;
   localparam int WATCHDOG_LIMIT = 1000;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [COORD_BITS-1:0]    req_pixel_x;
   logic [COORD_BITS-1:0]    req_pixel_y;
   logic                     rsp_strobe;
   logic [31:0]              rsp_pixel_color;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;
   int unsigned              mismatches;
   int unsigned              outstanding;
   int unsigned              stall_cycles;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   vertical_gradient_dither_pixel_top dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .rsp_strobe      (rsp_strobe),
      .rsp_pixel_color (rsp_pixel_color),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   vertical_gradient_dither_pixel_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .rsp_strobe      (rsp_strobe),
      .rsp_pixel_color (rsp_pixel_color),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   // call at a falling edge; returns at the falling edge after acceptance with start held
   task automatic send_pixel(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
      req_pixel_x <= x;
      req_pixel_y <= y;
      start       <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // drop start and wait for every pending result
   task automatic drain_pixels();
      start <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
   endtask

   // write the height, then read it back in the next setup cycle
   task automatic set_frame_height(input logic [HEIGHT_BITS-1:0] h, input bit junk_high);
      logic [CSR_DATA_BITS-1:0] junk;
      junk    = junk_high ? $urandom() : '0;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= HEIGHT_ADDR;
      pwdata  <= {junk[CSR_DATA_BITS-1:HEIGHT_BITS], h};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic run_phase(input logic [HEIGHT_BITS-1:0] h, input int n);
      int left;
      int burst;
      int gap;
      int rows;
      int ylim;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      drain_pixels();
      set_frame_height(h, 1'($urandom_range(0, 1)));
      rows = (h == 0) ? 1 : int'(h);
      ylim = ((rows > 4096) ? 4096 : rows) - 1;
      left = n;
      while (left > 0) begin
         burst = $urandom_range(1, 30);
         while (burst > 0 && left > 0) begin
            x = COORD_BITS'($urandom_range(0, 4095));
            // mostly rows inside the frame, the rest anywhere
            y = ($urandom_range(0, 9) < 6) ? COORD_BITS'($urandom_range(0, ylim))
                                          : COORD_BITS'($urandom_range(0, 4095));
            send_pixel(x, y);
            burst--;
            left--;
         end
         case ($urandom_range(0, 3))
            0: gap = 0;
            1: gap = $urandom_range(1, 3);
            2: gap = $urandom_range(4, 12);
            default: gap = $urandom_range(20, 40);
         endcase
         if (gap > 0 || left == 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else if ((start && !busy) || rsp_strobe || (psel && penable)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_pixel_x = '0;
      req_pixel_y = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // reset height: noise extremes, segment edges, bottom row and rows past the frame
      send_pixel(0, 0);
      send_pixel(1, 0);
      send_pixel(4095, 0);
      send_pixel(0, 647);
      send_pixel(0, 648);
      send_pixel(3, 809);
      send_pixel(0, 810);
      send_pixel(0, 1079);
      send_pixel(2, 1080);
      send_pixel(0, 4095);
      send_pixel(4095, 4095);

      // one-row frame: divisor of one, wrapped channels
      drain_pixels();
      set_frame_height(1, 1'b0);
      send_pixel(0, 0);
      send_pixel(1, 1);
      send_pixel(6, 2);
      send_pixel(0, 255);
      send_pixel(4095, 4095);

      drain_pixels();
      set_frame_height(0, 1'b0);
      send_pixel(0, 1);
      send_pixel(7, 4095);

      drain_pixels();
      set_frame_height(13'h1FFF, 1'b1);
      send_pixel(4095, 4095);

      run_phase(2, PHASE_PIXELS);
      run_phase(4096, PHASE_PIXELS);
      run_phase(13'h1FFF, PHASE_PIXELS);
      run_phase(0, PHASE_PIXELS);
      run_phase(1, PHASE_PIXELS);
      run_phase(720, PHASE_PIXELS);
      run_phase(HEIGHT_BITS'($urandom_range(1, 4096)), PHASE_PIXELS);
      run_phase(HEIGHT_BITS'($urandom_range(2, 64)), PHASE_PIXELS);
      run_phase(HEIGHT_BITS'($urandom_range(0, 8191)), PHASE_PIXELS);
      run_phase(1080, PHASE_PIXELS);

      drain_pixels();
      repeat (LATENCY + 8) @(negedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
